>>> hdl/cfdp_pkg.sv
// shared types and constants of the fused complex dot-product engine
package cfdp_pkg;

   localparam int unsigned FUSE_WIDTH = 6;
   localparam int unsigned WORD_BITS  = 32;
   localparam int unsigned PADDR_BITS = 5;

   typedef enum logic [1:0] {
      OP_START  = 2'd0,
      OP_ROW    = 2'd1,
      OP_FINISH = 2'd2
   } cfdp_op_type;

   typedef enum logic [2:0] {
      REG_CONJ_A   = 3'd0,
      REG_CONJ_X   = 3'd1,
      REG_ALPHA_RE = 3'd2,
      REG_ALPHA_IM = 3'd3,
      REG_BETA_RE  = 3'd4,
      REG_BETA_IM  = 3'd5
   } cfdp_reg_type;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [31:0] elem0;
      logic [31:0] elem1;
      logic [31:0] elem2;
      logic [31:0] elem3;
      logic [31:0] elem4;
      logic [31:0] elem5;
      logic [31:0] x_val;
   } cfdp_req_type;

   typedef struct packed {
      logic [31:0] y_out0;
      logic [31:0] y_out1;
      logic [31:0] y_out2;
      logic [31:0] y_out3;
      logic [31:0] y_out4;
      logic [31:0] y_out5;
   } cfdp_rsp_type;

   typedef struct packed {
      logic               conj_a;
      logic               conj_x;
      logic signed [15:0] alpha_re;
      logic signed [15:0] alpha_im;
      logic signed [15:0] beta_re;
      logic signed [15:0] beta_im;
   } cfdp_cfg_type;

   // per-cycle commands from the top level to every lane
   typedef struct packed {
      logic start;
      logic row;
      logic fin_load;
      logic out_load;
   } cfdp_ctl_type;

endpackage

>>> hdl/cfdp_lane.sv
// one column lane: accumulators, held y, finish products and saturated result
module cfdp_lane #(
   parameter int unsigned ACC_BITS = 48
) (
   input  logic                    clock,
   input  logic                    reset,
   input  cfdp_pkg::cfdp_ctl_type  ctl,
   input  cfdp_pkg::cfdp_cfg_type  cfg,
   input  logic [31:0]             elem,
   input  logic [31:0]             x_val,
   output logic [31:0]             y_out
);
   import cfdp_pkg::*;

   localparam int unsigned LB  = ACC_BITS / 2;       // low half, unsigned
   localparam int unsigned HB  = ACC_BITS - LB;      // high half, signed
   localparam int unsigned DHW = HB + 18;
   localparam int unsigned DLW = LB + 19;
   localparam int unsigned TW  = ACC_BITS + 19;
   localparam int unsigned SW  = TW - 30;
   localparam int unsigned FW  = SW + 1;

   // row products
   logic signed [15:0] ar, xr;
   logic signed [16:0] ai, xi;
   logic signed [31:0] p_rr;
   logic signed [33:0] p_ii;
   logic signed [32:0] p_ri, p_ir;
   logic signed [34:0] d_re, d_im;

   logic signed [ACC_BITS-1:0] acc_re_ff, acc_re_in, acc_im_ff, acc_im_in;
   logic [31:0]                y_held_ff, y_held_in;

   // finish products
   logic signed [16:0]       c_re, c_im;
   logic signed [HB-1:0]     h_re, h_im;
   logic signed [LB:0]       l_re, l_im;
   logic signed [HB+16:0]    ph_rr, ph_ii, ph_ri, ph_ir;
   logic signed [LB+17:0]    pl_rr, pl_ii, pl_ri, pl_ir;
   logic signed [15:0]       yr, yi;
   logic signed [31:0]       pb_rr, pb_ii, pb_ri, pb_ir;

   logic signed [DHW-1:0] dh_re_ff, dh_re_in, dh_im_ff, dh_im_in;
   logic signed [DLW-1:0] dl_re_ff, dl_re_in, dl_im_ff, dl_im_in;
   logic signed [32:0]    b_re_ff, b_re_in, b_im_ff, b_im_in;
   logic [31:0]           y_out_ff, y_out_in;

   // floor((dh*2^LB + dl) / 2^30) + floor(b / 2^15), saturated to 16 bits
   function automatic logic [15:0] combine(input logic signed [DHW-1:0] dh,
                                           input logic signed [DLW-1:0] dl,
                                           input logic signed [32:0]    b);
      logic signed [TW-1:0] total;
      logic signed [SW-1:0] scaled;
      logic signed [17:0]   bscaled;
      logic signed [FW-1:0] sum;
      logic signed [FW-1:0] sat_max;
      logic signed [FW-1:0] sat_min;
      total   = (TW'(dh) <<< LB) + TW'(dl);
      scaled  = SW'(total >>> 30);
      bscaled = 18'(b >>> 15);
      sum     = FW'(scaled) + FW'(bscaled);
      sat_max = FW'(32767);
      sat_min = FW'(-32768);
      if (sum > sat_max) begin
         combine = 16'h7fff;
      end else if (sum < sat_min) begin
         combine = 16'h8000;
      end else begin
         combine = sum[15:0];
      end
   endfunction

   always_comb begin
      ar = elem[15:0];
      xr = x_val[15:0];
      ai = cfg.conj_a ? -17'(signed'(elem[31:16])) : 17'(signed'(elem[31:16]));
      xi = cfg.conj_x ? -17'(signed'(x_val[31:16])) : 17'(signed'(x_val[31:16]));
      p_rr = ar * xr;
      p_ii = ai * xi;
      p_ri = ar * xi;
      p_ir = ai * xr;
      d_re = 35'(p_rr) - 35'(p_ii);
      d_im = 35'(p_ri) + 35'(p_ir);
   end

   always_comb begin
      acc_re_in = acc_re_ff;
      acc_im_in = acc_im_ff;
      y_held_in = y_held_ff;
      if (ctl.start) begin
         acc_re_in = '0;
         acc_im_in = '0;
         y_held_in = elem;
      end else if (ctl.row) begin
         acc_re_in = acc_re_ff + ACC_BITS'(d_re);
         acc_im_in = acc_im_ff + ACC_BITS'(d_im);
      end
   end

   // alpha times the split accumulators, beta times held y
   always_comb begin
      c_re  = 17'(cfg.alpha_re);
      c_im  = 17'(cfg.alpha_im);
      h_re  = acc_re_ff[ACC_BITS-1:LB];
      h_im  = acc_im_ff[ACC_BITS-1:LB];
      l_re  = signed'({1'b0, acc_re_ff[LB-1:0]});
      l_im  = signed'({1'b0, acc_im_ff[LB-1:0]});
      ph_rr = c_re * h_re;
      ph_ii = c_im * h_im;
      ph_ri = c_re * h_im;
      ph_ir = c_im * h_re;
      pl_rr = c_re * l_re;
      pl_ii = c_im * l_im;
      pl_ri = c_re * l_im;
      pl_ir = c_im * l_re;
      dh_re_in = DHW'(ph_rr) - DHW'(ph_ii);
      dh_im_in = DHW'(ph_ri) + DHW'(ph_ir);
      dl_re_in = DLW'(pl_rr) - DLW'(pl_ii);
      dl_im_in = DLW'(pl_ri) + DLW'(pl_ir);
      yr    = y_held_ff[15:0];
      yi    = y_held_ff[31:16];
      pb_rr = cfg.beta_re * yr;
      pb_ii = cfg.beta_im * yi;
      pb_ri = cfg.beta_re * yi;
      pb_ir = cfg.beta_im * yr;
      b_re_in = 33'(pb_rr) - 33'(pb_ii);
      b_im_in = 33'(pb_ri) + 33'(pb_ir);
   end

   always_comb begin
      y_out_in = {combine(dh_im_ff, dl_im_ff, b_im_ff),
                  combine(dh_re_ff, dl_re_ff, b_re_ff)};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_re_ff <= '0;
         acc_im_ff <= '0;
         y_held_ff <= '0;
      end else begin
         acc_re_ff <= acc_re_in;
         acc_im_ff <= acc_im_in;
         y_held_ff <= y_held_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.fin_load) begin
         dh_re_ff <= dh_re_in;
         dh_im_ff <= dh_im_in;
         dl_re_ff <= dl_re_in;
         dl_im_ff <= dl_im_in;
         b_re_ff  <= b_re_in;
         b_im_ff  <= b_im_in;
      end
      if (ctl.out_load) begin
         y_out_ff <= y_out_in;
      end
   end

   assign y_out = y_out_ff;

endmodule

>>> hdl/fused_complex_dot_products.sv
// top level of the six-column fused complex dot-product engine
//
// channel   direction  handshake                 payload
// req       in         req_valid / req_stall     cfdp_req_type (opcode, elem0..5, x_val)
// rsp       out        rsp_valid / rsp_stall     cfdp_rsp_type (y_out0..5)
// csr       in         psel/penable/pwrite/pready 32-bit registers at byte address 4*i
//
// one item a cycle while req_stall is low; start and row items finish in the input
// register stage, finish items pass the product stage before the result register
// reset clears the valid bits, the accumulators and held y, and presets the registers
// a stalled result holds the result register; the product stage and input
// register still absorb items, and req_stall rises only when a finish item
// finds both of them full
module fused_complex_dot_products #(
   parameter int unsigned ACC_BITS = 48
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // input items
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  cfdp_pkg::cfdp_req_type               req_data,
   // result items
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output cfdp_pkg::cfdp_rsp_type               rsp_data,
   // register port
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [cfdp_pkg::PADDR_BITS-1:0]      paddr,
   input  logic [31:0]                          pwdata,
   output logic [31:0]                          prdata,
   output logic                                 pready
);
   import cfdp_pkg::*;

   // register file
   cfdp_cfg_type cfg_ff, cfg_in;
   cfdp_reg_type reg_sel;
   logic         reg_write;

   // pipeline control
   logic         s1_valid_ff, s1_valid_in;
   cfdp_req_type s1_data_ff;
   logic         s2_valid_ff, s2_valid_in;
   logic         rsp_valid_ff, rsp_valid_in;
   logic         req_accept;
   logic         s1_fin, s1_retire, s2_free, out_load;
   cfdp_ctl_type ctl;

   logic [FUSE_WIDTH-1:0][31:0] elem_s1;
   logic [FUSE_WIDTH-1:0][31:0] y_lane;

   // register port: writes complete in the access phase, reads are combinational
   assign reg_sel   = cfdp_reg_type'(paddr[4:2]);
   assign reg_write = psel & penable & pwrite;
   assign pready    = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (reg_write) begin
         unique case (reg_sel)
            REG_CONJ_A:   cfg_in.conj_a   = pwdata[0];
            REG_CONJ_X:   cfg_in.conj_x   = pwdata[0];
            REG_ALPHA_RE: cfg_in.alpha_re = pwdata[15:0];
            REG_ALPHA_IM: cfg_in.alpha_im = pwdata[15:0];
            REG_BETA_RE:  cfg_in.beta_re  = pwdata[15:0];
            REG_BETA_IM:  cfg_in.beta_im  = pwdata[15:0];
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_sel)
         REG_CONJ_A:   prdata = {31'b0, cfg_ff.conj_a};
         REG_CONJ_X:   prdata = {31'b0, cfg_ff.conj_x};
         REG_ALPHA_RE: prdata = {16'b0, cfg_ff.alpha_re};
         REG_ALPHA_IM: prdata = {16'b0, cfg_ff.alpha_im};
         REG_BETA_RE:  prdata = {16'b0, cfg_ff.beta_re};
         REG_BETA_IM:  prdata = {16'b0, cfg_ff.beta_im};
         default:      prdata = '0;
      endcase
   end

   // result register empties or is taken: the product stage moves on
   assign out_load  = s2_valid_ff & (~rsp_valid_ff | ~rsp_stall);
   assign s2_free   = ~s2_valid_ff | out_load;
   assign s1_fin    = (s1_data_ff.opcode == OP_FINISH);
   // start, row and unknown codes always retire; finish needs a free product stage
   assign s1_retire = s1_valid_ff & (~s1_fin | s2_free);
   assign req_stall = s1_valid_ff & ~s1_retire;
   assign req_accept = req_valid & ~req_stall;

   assign ctl.start    = s1_valid_ff & (s1_data_ff.opcode == OP_START);
   assign ctl.row      = s1_valid_ff & (s1_data_ff.opcode == OP_ROW);
   assign ctl.fin_load = s1_valid_ff & s1_fin & s2_free;
   assign ctl.out_load = out_load;

   assign s1_valid_in  = req_accept | (s1_valid_ff & ~s1_retire);
   assign s2_valid_in  = ctl.fin_load | (s2_valid_ff & ~out_load);
   assign rsp_valid_in = out_load | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         cfg_ff.conj_a   <= 1'b0;
         cfg_ff.conj_x   <= 1'b0;
         cfg_ff.alpha_re <= 16'sh7fff;
         cfg_ff.alpha_im <= 16'sh0000;
         cfg_ff.beta_re  <= 16'sh0000;
         cfg_ff.beta_im  <= 16'sh0000;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         cfg_ff       <= cfg_in;
      end
   end

   // input register payload
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_data_ff <= req_data;
      end
   end

   assign elem_s1[0] = s1_data_ff.elem0;
   assign elem_s1[1] = s1_data_ff.elem1;
   assign elem_s1[2] = s1_data_ff.elem2;
   assign elem_s1[3] = s1_data_ff.elem3;
   assign elem_s1[4] = s1_data_ff.elem4;
   assign elem_s1[5] = s1_data_ff.elem5;

   // one lane per fused column
   for (genvar i = 0; i < FUSE_WIDTH; i++) begin : g_lane
      cfdp_lane #(
         .ACC_BITS (ACC_BITS)
      ) u_lane (
         .clock (clock),
         .reset (reset),
         .ctl   (ctl),
         .cfg   (cfg_ff),
         .elem  (elem_s1[i]),
         .x_val (s1_data_ff.x_val),
         .y_out (y_lane[i])
      );
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_data.y_out0 = y_lane[0];
   assign rsp_data.y_out1 = y_lane[1];
   assign rsp_data.y_out2 = y_lane[2];
   assign rsp_data.y_out3 = y_lane[3];
   assign rsp_data.y_out4 = y_lane[4];
   assign rsp_data.y_out5 = y_lane[5];

endmodule

>>> hdl/cfdp_checker.sv
// port-level checks of the fused complex dot-product engine and their bind
module cfdp_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_stall,
   input logic                             rsp_valid,
   input logic                             rsp_stall,
   input cfdp_pkg::cfdp_rsp_type           rsp_data,
   input logic                             psel,
   input logic                             penable,
   input logic                             pwrite,
   input logic [cfdp_pkg::PADDR_BITS-1:0]  paddr,
   input logic [31:0]                      pwdata,
   input logic [31:0]                      prdata
);
   import cfdp_pkg::*;

   // the input side only backs up behind a stalled result
   a_stall_needs_full_output: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("input stalled while result side free");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled result changed");

   // after reset the pipeline is empty
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> (!rsp_valid && !req_stall))
      else $error("pipeline not empty after reset");

   // a write to alpha_re reads back in the next access
   a_alpha_readback: assert property (@(posedge clock) disable iff (reset)
      (psel && penable && pwrite && paddr[4:2] == REG_ALPHA_RE)
      ##1 (psel && penable && !pwrite && paddr[4:2] == REG_ALPHA_RE)
      |-> (prdata[15:0] == $past(pwdata[15:0])))
      else $error("alpha_re read back wrong");

endmodule

bind fused_complex_dot_products cfdp_checker u_cfdp_checker (.*);

>>> tb/fused_complex_dot_products_tb.sv
// self-checking testbench of the six-column fused complex dot-product engine
module fused_complex_dot_products_tb;
   import cfdp_pkg::*;

   // opcode that the block ignores
   localparam logic [1:0] OP_UNUSED = 2'd3;
   // edges to let pass once the last result is in
   localparam int SETTLE_CYCLES = 8;
   // rows of full-scale products, enough to drive the real parts of the fixed lanes into saturation
   localparam int FULL_SCALE_ROWS = 24;

   typedef logic [FUSE_WIDTH-1:0][31:0] lane_words_type;

   logic           clock = 1'b0;
   logic           reset;
   logic           req_valid;
   logic           req_stall;
   cfdp_req_type   req_data;
   logic           rsp_valid;
   logic           rsp_stall;
   cfdp_rsp_type   rsp_data;
   logic           psel;
   logic           penable;
   logic           pwrite;
   logic [PADDR_BITS-1:0] paddr;
   logic [31:0]    pwdata;
   logic [31:0]    prdata;
   logic           pready;

   // shared between the stimulus, the stall process and the result check
   int  errors = 0;
   int  hold_len = 0;       // cycles the receiver still has to hold off
   bit  no_gaps = 1'b0;     // stretches with neither side idling

   // predicted engine state and register copy
   logic signed [47:0] acc_re [FUSE_WIDTH];
   logic signed [47:0] acc_im [FUSE_WIDTH];
   logic [31:0]        y_hold [FUSE_WIDTH];
   bit                 m_conj_a, m_conj_x;
   logic signed [15:0] m_alpha_re, m_alpha_im, m_beta_re, m_beta_im;

   // updated y vectors still to come out, oldest first
   lane_words_type y_expected [$];

   fused_complex_dot_products dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------
   // prediction
   // ---------------------------------------------------------------

   // clamp one wide part to the q1.15 range
   function automatic logic [15:0] sat16(input logic signed [79:0] v);
      if (v > 80'sd32767) return 16'h7fff;
      if (v < -80'sd32768) return 16'h8000;
      return v[15:0];
   endfunction

   // state after reset: zero sums, zero y, alpha one, beta zero
   task automatic clear_model();
      int i;
      for (i = 0; i < FUSE_WIDTH; i++) begin
         acc_re[i] = '0;
         acc_im[i] = '0;
         y_hold[i] = '0;
      end
      m_conj_a = 1'b0;
      m_conj_x = 1'b0;
      m_alpha_re = 16'sd32767;
      m_alpha_im = '0;
      m_beta_re = '0;
      m_beta_im = '0;
   endtask

   // advance the predicted state by one accepted item
   task automatic predict_dot_update(input cfdp_req_type it);
      int i;
      lane_words_type w, y_new;
      longint xr, xi, er, ei;
      logic signed [79:0] yr, yi, cr, ci, a_re, a_im, b_re, b_im, t_re, t_im;
      w = {it.elem5, it.elem4, it.elem3, it.elem2, it.elem1, it.elem0};
      case (it.opcode)
         OP_START: begin
            for (i = 0; i < FUSE_WIDTH; i++) begin
               y_hold[i] = w[i];
               acc_re[i] = '0;
               acc_im[i] = '0;
            end
         end
         OP_ROW: begin
            xr = longint'($signed(it.x_val[15:0]));
            xi = longint'($signed(it.x_val[31:16]));
            if (m_conj_x) xi = -xi;
            for (i = 0; i < FUSE_WIDTH; i++) begin
               er = longint'($signed(w[i][15:0]));
               ei = longint'($signed(w[i][31:16]));
               if (m_conj_a) ei = -ei;
               // sums wrap at the accumulator width
               acc_re[i] = acc_re[i] + 48'(er * xr - ei * xi);
               acc_im[i] = acc_im[i] + 48'(er * xi + ei * xr);
            end
         end
         OP_FINISH: begin
            a_re = 80'(m_alpha_re);
            a_im = 80'(m_alpha_im);
            b_re = 80'(m_beta_re);
            b_im = 80'(m_beta_im);
            for (i = 0; i < FUSE_WIDTH; i++) begin
               yr = 80'($signed(y_hold[i][15:0]));
               yi = 80'($signed(y_hold[i][31:16]));
               cr = 80'(acc_re[i]);
               ci = 80'(acc_im[i]);
               // arithmetic shifts floor, only the final sum saturates
               t_re = ((b_re * yr - b_im * yi) >>> 15) + ((a_re * cr - a_im * ci) >>> 30);
               t_im = ((b_re * yi + b_im * yr) >>> 15) + ((a_re * ci + a_im * cr) >>> 30);
               y_new[i] = {sat16(t_im), sat16(t_re)};
            end
            y_expected.push_back(y_new);
         end
         default: ;
      endcase
   endtask

   // ---------------------------------------------------------------
   // random values
   // ---------------------------------------------------------------

   // gap length: mostly none or short, now and then long
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [15:0] pick_half();
      case ($urandom_range(0, 5))
         0: return 16'h8000;
         1: return 16'h7fff;
         2: return 16'h0000;
         3: return 16'hffff;
         4: return 16'h0001;
         default: return 16'($urandom);
      endcase
   endfunction

   // packed complex word, biased toward the part extremes
   function automatic logic [31:0] pick_word();
      if ($urandom_range(0, 99) < 30) return {pick_half(), pick_half()};
      return $urandom;
   endfunction

   function automatic logic [15:0] pick16();
      if ($urandom_range(0, 99) < 30) return pick_half();
      return 16'($urandom);
   endfunction

   function automatic lane_words_type rand_lanes();
      lane_words_type w;
      int i;
      for (i = 0; i < FUSE_WIDTH; i++) w[i] = pick_word();
      return w;
   endfunction

   // ---------------------------------------------------------------
   // drivers
   // ---------------------------------------------------------------

   // offer one item, hold it until taken, then predict its effect
   // valid is only lowered ahead of a gap, so a back-to-back item keeps it high
   task automatic send_op(input logic [1:0] op, input lane_words_type w,
                          input logic [31:0] x);
      cfdp_req_type it;
      int gap;
      it.opcode = op;
      it.elem0 = w[0];
      it.elem1 = w[1];
      it.elem2 = w[2];
      it.elem3 = w[3];
      it.elem4 = w[4];
      it.elem5 = w[5];
      it.x_val = x;
      gap = no_gaps ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_data <= it;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_dot_update(it);
   endtask

   // drop valid, wait for every predicted result, then let the pipe settle
   task automatic finish_phase();
      req_valid <= 1'b0;
      while (y_expected.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // register write (setup, access) followed by a read back of the same register
   task automatic write_reg(input cfdp_reg_type idx, input logic [31:0] val);
      logic [31:0] mask;
      mask = (idx == REG_CONJ_A || idx == REG_CONJ_X) ? 32'h1 : 32'hffff;
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= val;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      // read setup
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      if ((prdata & mask) !== (val & mask)) begin
         errors++;
         $display("%0t: register %s read back, expected %h actual %h",
                  $time, idx.name(), val & mask, prdata & mask);
      end
      psel <= 1'b0;
      penable <= 1'b0;
      case (idx)
         REG_CONJ_A:   m_conj_a = val[0];
         REG_CONJ_X:   m_conj_x = val[0];
         REG_ALPHA_RE: m_alpha_re = val[15:0];
         REG_ALPHA_IM: m_alpha_im = val[15:0];
         REG_BETA_RE:  m_beta_re = val[15:0];
         REG_BETA_IM:  m_beta_im = val[15:0];
         default: ;
      endcase
   endtask

   // all six registers, signed parts sign-extended onto the bus
   task automatic set_config(input bit ca, input bit cx,
                             input logic signed [15:0] ar, input logic signed [15:0] ai,
                             input logic signed [15:0] br, input logic signed [15:0] bi);
      write_reg(REG_CONJ_A, {31'b0, ca});
      write_reg(REG_CONJ_X, {31'b0, cx});
      write_reg(REG_ALPHA_RE, 32'(ar));
      write_reg(REG_ALPHA_IM, 32'(ai));
      write_reg(REG_BETA_RE, 32'(br));
      write_reg(REG_BETA_IM, 32'(bi));
   endtask

   // ---------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------

   // register defaults: alpha one, beta zero, no conjugation
   task automatic test_reset_state();
      lane_words_type corners;
      corners = {32'hffffffff, 32'h00000000, 32'h7fff8000,
                 32'h80007fff, 32'h80008000, 32'h7fff7fff};
      // finish before any start works on the zero state
      send_op(OP_FINISH, rand_lanes(), pick_word());
      // start ignores x_val
      send_op(OP_START, corners, $urandom);
      send_op(OP_ROW, corners, 32'h80008000);
      send_op(OP_ROW, {FUSE_WIDTH{32'h80008000}}, 32'h7fff7fff);
      // opcode the block ignores
      send_op(OP_UNUSED, rand_lanes(), pick_word());
      // a second finish repeats the first
      send_op(OP_FINISH, rand_lanes(), pick_word());
      send_op(OP_FINISH, rand_lanes(), pick_word());
      send_op(OP_ROW, rand_lanes(), 32'hffffffff);
      send_op(OP_FINISH, rand_lanes(), pick_word());
      finish_phase();
   endtask

   // every combination of matrix and vector conjugation
   task automatic test_conjugation();
      int c;
      for (c = 0; c < 4; c++) begin
         set_config(c[1], c[0], 16'sd32767, -16'sd12345, 16'sd16384, -16'sd16384);
         send_op(OP_START, rand_lanes(), pick_word());
         send_op(OP_ROW, rand_lanes(), pick_word());
         send_op(OP_FINISH, rand_lanes(), pick_word());
         finish_phase();
      end
   endtask

   // alpha zero leaves beta*y, then every scale at its minimum to saturate
   task automatic test_scale_extremes();
      set_config(1'b0, 1'b0, 16'sd0, 16'sd0, 16'sd32767, -16'sd32768);
      send_op(OP_START, rand_lanes(), pick_word());
      send_op(OP_ROW, rand_lanes(), pick_word());
      send_op(OP_FINISH, rand_lanes(), pick_word());
      finish_phase();
      set_config(1'b1, 1'b0, -16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768);
      send_op(OP_START, {FUSE_WIDTH{32'h7fff7fff}}, pick_word());
      send_op(OP_ROW, {FUSE_WIDTH{32'h80007fff}}, 32'h80008000);
      send_op(OP_ROW, {FUSE_WIDTH{32'h80008000}}, 32'h80008000);
      send_op(OP_FINISH, rand_lanes(), pick_word());
      finish_phase();
   endtask

   // full-scale products back to back, sums far beyond the output range
   task automatic test_full_scale_rows();
      int k;
      lane_words_type w;
      set_config(1'b0, 1'b1, 16'sd32767, 16'sd0, 16'sd0, 16'sd0);
      no_gaps = 1'b1;
      send_op(OP_START, '0, '0);
      for (k = 0; k < FULL_SCALE_ROWS; k++) begin
         w = {FUSE_WIDTH{32'h80008000}};
         // one lane takes random content so the sums are not all alike
         w[FUSE_WIDTH-1] = pick_word();
         send_op(OP_ROW, w, 32'h80008000);
         if (k == FULL_SCALE_ROWS / 2) send_op(OP_FINISH, rand_lanes(), pick_word());
      end
      send_op(OP_FINISH, rand_lanes(), pick_word());
      finish_phase();
      no_gaps = 1'b0;
   endtask

   // receiver holds off for a long stretch while items keep coming
   task automatic test_result_backpressure();
      int k;
      set_config(1'b1, 1'b1, pick16(), pick16(), pick16(), pick16());
      no_gaps = 1'b1;
      hold_len = 300;
      for (k = 0; k < 20; k++) begin
         send_op(OP_START, rand_lanes(), pick_word());
         send_op(OP_ROW, rand_lanes(), pick_word());
         send_op(OP_FINISH, rand_lanes(), pick_word());
      end
      finish_phase();
      no_gaps = 1'b0;
   endtask

   // mostly whole start/rows/finish sequences, the rest stray items
   task automatic test_random_sequences();
      int phase, count, n, r;
      for (phase = 0; phase < 11; phase++) begin
         case (phase)
            0: set_config(1'b1, 1'b1, -16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768);
            1: set_config(1'b0, 1'b0, 16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767);
            default: set_config(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                pick16(), pick16(), pick16(), pick16());
         endcase
         no_gaps = (phase % 5 == 3);
         count = 0;
         while (count < 135) begin
            r = $urandom_range(0, 99);
            if (r < 80) begin
               send_op(OP_START, rand_lanes(), pick_word());
               n = ($urandom_range(0, 19) == 0) ? $urandom_range(7, 24) : $urandom_range(0, 6);
               repeat (n) send_op(OP_ROW, rand_lanes(), pick_word());
               send_op(OP_FINISH, rand_lanes(), pick_word());
               count += n + 2;
               if ($urandom_range(0, 9) == 0) begin
                  send_op(OP_FINISH, rand_lanes(), pick_word());
                  count++;
               end
            end else if (r < 88) begin
               // ignored, not counted
               send_op(OP_UNUSED, rand_lanes(), pick_word());
            end else if (r < 94) begin
               send_op(OP_ROW, rand_lanes(), pick_word());
               count++;
            end else begin
               send_op(OP_FINISH, rand_lanes(), pick_word());
               count++;
            end
         end
         finish_phase();
      end
      no_gaps = 1'b0;
   endtask

   // ---------------------------------------------------------------
   // receiver: random stalls, a counted hold-off on request
   // ---------------------------------------------------------------
   initial begin : recv_stall
      int run;
      bit stalled;
      run = 0;
      stalled = 1'b0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_len > 0) begin
            hold_len--;
            rsp_stall <= 1'b1;
         end else if (no_gaps) begin
            rsp_stall <= 1'b0;
         end else begin
            if (run == 0) begin
               stalled = ($urandom_range(0, 99) < 30);
               run = stalled ? pick_gap() + 1 : $urandom_range(1, 8);
            end
            run--;
            rsp_stall <= stalled;
         end
      end
   end

   // ---------------------------------------------------------------
   // result check against the oldest prediction
   // ---------------------------------------------------------------
   always @(posedge clock) begin : check_results
      lane_words_type got, want;
      int i;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = {rsp_data.y_out5, rsp_data.y_out4, rsp_data.y_out3,
                rsp_data.y_out2, rsp_data.y_out1, rsp_data.y_out0};
         if (y_expected.size() == 0) begin
            errors++;
            $display("%0t: result with none expected, expected nothing actual %h", $time, got);
         end else begin
            want = y_expected.pop_front();
            for (i = 0; i < FUSE_WIDTH; i++) begin
               if (got[i] !== want[i]) begin
                  errors++;
                  $display("%0t: y_out%0d expected %h actual %h", $time, i, want[i], got[i]);
               end
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // main sequence
   // ---------------------------------------------------------------
   initial begin
      clear_model();
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_data <= '0;
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= '0;
      pwdata <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_state();
      test_conjugation();
      test_scale_extremes();
      test_full_scale_rows();
      test_result_backpressure();
      test_random_sequences();

      finish_phase();
      if (errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   // hard stop well past the slowest correct run
   initial begin
      #12000000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule

>>> filelist.f
hdl/cfdp_pkg.sv
hdl/cfdp_lane.sv
hdl/fused_complex_dot_products.sv
hdl/cfdp_checker.sv
tb/fused_complex_dot_products_tb.sv
